[rtl/fts_pkg.sv]
`default_nettype none
package fts_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BIT_TOP  = 7;
  localparam int unsigned SIM_W    = 17;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIV_STEPS = SIM_W;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned INC_W    = 4;
  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] ADDR_MODE = 2'd0;

  localparam logic MODE_BITS  = 1'b0;
  localparam logic MODE_BYTES = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic              last_pair;
  } fts_in_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic [CNT_W-1:0] common_count;
    logic [CNT_W-1:0] union_count;
    logic             empty_union;
  } fts_out_t;

  // controller to datapath
  typedef struct packed {
    logic accum;
    logic snap;
    logic div_step;
    logic load_out;
  } fts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } fts_sts_t;

  function automatic logic [INC_W-1:0] ones8(input logic [BYTE_W-1:0] v);
    logic [INC_W-1:0] n;
    n = '0;
    for (int i = BIT_TOP; i >= 0; i--) begin
      n = n + INC_W'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/fts_ctrl.sv]
`default_nettype none
module fts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_stall,
  input  wire fts_pkg::fts_sts_t sts,
  output fts_pkg::fts_cmd_t      cmd
);
  import fts_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM  = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign in_stall = (state_r != ST_ACCUM);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.accum    = 1'b0;
    cmd.snap     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_ACCUM: begin
        cmd.accum = accept;
        if (accept && in_last) begin
          cmd.snap  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fts_dp.sv]
`default_nettype none
module fts_dp #(
  parameter int unsigned MAX_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mode,
  input  wire fts_pkg::fts_in_t  in_data,
  input  wire fts_pkg::fts_cmd_t cmd,
  output fts_pkg::fts_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fts_pkg::fts_out_t      out_data
);
  import fts_pkg::*;

  localparam int unsigned AW  = $clog2(BYTE_W * MAX_BYTES + 1);
  localparam int unsigned BCW = $clog2(MAX_BYTES + 1);
  localparam int unsigned EW  = (AW > CNT_W) ? AW : CNT_W;

  logic [AW-1:0]    common_r, common_nxt;
  logic [AW-1:0]    union_r, union_nxt;
  logic [BCW-1:0]   bcnt_r, bcnt_nxt;
  logic [INC_W-1:0] inc_common, inc_union;
  logic             eq;

  logic [AW:0]      rem_r, rem_nxt;
  logic [AW-1:0]    den_r, den_nxt;
  logic [AW-1:0]    num_r, num_nxt;
  logic [SIM_W-1:0] quo_r, quo_nxt;
  logic             empty_r, empty_nxt;
  logic             ge;
  logic [AW:0]      diff;
  logic [EW-1:0]    num_ext, den_ext;

  fts_out_t out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;

  // per-pair increments; in bit mode union grows by the bits set in either byte, in byte mode by 1 or 2
  always_comb begin
    eq = (in_data.byte_a == in_data.byte_b);
    if (mode == MODE_BYTES) begin
      inc_common = INC_W'(eq);
      inc_union  = eq ? INC_W'(1) : INC_W'(2);
    end else begin
      inc_common = ones8(in_data.byte_a & in_data.byte_b);
      inc_union  = ones8(in_data.byte_a | in_data.byte_b);
    end
  end

  always_comb begin
    common_nxt = common_r;
    union_nxt  = union_r;
    bcnt_nxt   = bcnt_r;
    if (cmd.accum && (bcnt_r < BCW'(MAX_BYTES))) begin
      common_nxt = common_r + AW'(inc_common);
      union_nxt  = union_r + AW'(inc_union);
      bcnt_nxt   = bcnt_r + BCW'(1);
    end
  end

  // restoring divider, one quotient bit per step, common <= union
  assign diff = rem_r - {1'b0, den_r};
  assign ge   = (rem_r >= {1'b0, den_r});

  always_comb begin
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    empty_nxt = empty_r;
    if (cmd.snap) begin
      rem_nxt   = {1'b0, common_nxt};
      den_nxt   = union_nxt;
      num_nxt   = common_nxt;
      quo_nxt   = '0;
      empty_nxt = (union_nxt == '0);
    end else if (cmd.div_step) begin
      rem_nxt = {(ge ? diff[AW-1:0] : rem_r[AW-1:0]), 1'b0};
      quo_nxt = {quo_r[SIM_W-2:0], ge};
    end
  end

  assign num_ext = EW'(num_r);
  assign den_ext = EW'(den_r);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_nxt.similarity   = empty_r ? '0 : quo_r;
      out_nxt.common_count = num_ext[CNT_W-1:0];
      out_nxt.union_count  = den_ext[CNT_W-1:0];
      out_nxt.empty_union  = empty_r;
      out_valid_nxt        = 1'b1;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_r    <= '0;
      union_r     <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.snap) begin
      common_r    <= '0;
      union_r     <= '0;
      bcnt_r      <= '0;
      out_valid_r <= out_valid_nxt;
    end else begin
      common_r    <= common_nxt;
      union_r     <= union_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    empty_r <= empty_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire

[rtl/fingerprint_tanimoto_similarity_core.sv]
// Tanimoto similarity of two fingerprints streamed one byte pair per transfer.
// Input channel (in_valid/in_stall/in_data): byte_a, byte_b and last_pair.
// Pairs are taken one per cycle while in_stall is low and folded into a common count and a union
// count; pairs beyond MAX_BYTES in one fingerprint are dropped until the
// pair marked last. Bit mode counts set bits, byte mode counts equal bytes.
// The pair marked last closes the fingerprint: in_stall then rises while
// a restoring divider produces common/union as Q1.16, one quotient bit
// per cycle, and the result is then moved into the output register,
// which drives out_valid/out_data. An empty union gives similarity 0
// with empty_union set.
// If out_stall holds the previous result, the new result waits in the
// divider and the input stays stalled until the output register frees.
// APB register at byte address 0, bit 0: compare_mode (0 bits, 1 bytes).
// Reset (rst_n low, synchronous) clears counts, mode and out_valid.
`default_nettype none
module fingerprint_tanimoto_similarity_core #(
  parameter int unsigned MAX_BYTES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire fts_pkg::fts_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output fts_pkg::fts_out_t                    out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fts_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [fts_pkg::PDATA_W-1:0]     pwdata,
  output logic [fts_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import fts_pkg::*;

  logic     mode_r, mode_nxt;
  fts_cmd_t cmd;
  fts_sts_t sts;

  assign pready = 1'b1;

  // single register, word aligned
  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && pready && (paddr == ADDR_MODE)) begin
      mode_nxt = pwdata[0];
    end
  end

  assign prdata = {{(PDATA_W-1){1'b0}}, mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BITS;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_pair),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fts_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[bench/testbench.sv]
module testbench;
  import fts_pkg::*;

  localparam int unsigned PAIR_LIMIT    = 256;
  localparam int unsigned RANDOM_PAIRS  = 1270;
  localparam int unsigned DIVIDE_SETTLE = 24;
  localparam int unsigned LONG_HOLD     = 160;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DIR_ROWS      = 19;
  localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(0);

  typedef enum logic {ROW_PAIR, ROW_MODE} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic      mode;
    fts_in_t   pair;
    logic      typed;
    fts_out_t  score;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fts_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fts_out_t           out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor state
  logic        mode_now = MODE_BITS;
  int unsigned common_bits = 0;
  int unsigned a_bits = 0;
  int unsigned b_bits = 0;
  int unsigned pairs_held = 0;

  fts_out_t    pending_scores [$];
  stim_row_t   dir_rows [DIR_ROWS];
  int unsigned pairs_sent = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  fingerprint_tanimoto_similarity_core #(
    .MAX_BYTES(PAIR_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // fold one pair into the running counts; on the last pair give the score
  task automatic fold_pair(input fts_in_t p, output bit done, output fts_out_t r);
    int unsigned       uni;
    longint unsigned   q;
    done = 1'b0;
    r = '0;
    if (pairs_held < PAIR_LIMIT) begin
      if (mode_now == MODE_BYTES) begin
        common_bits += (p.byte_a == p.byte_b) ? 1 : 0;
        a_bits += 1;
        b_bits += 1;
      end else begin
        common_bits += $countones(p.byte_a & p.byte_b);
        a_bits += $countones(p.byte_a);
        b_bits += $countones(p.byte_b);
      end
      pairs_held++;
    end
    if (p.last_pair) begin
      uni = a_bits + b_bits - common_bits;
      q = 0;
      if (uni != 0) q = (longint'(common_bits) << FRAC_W) / uni;
      r.similarity   = SIM_W'(q);
      r.common_count = CNT_W'(common_bits);
      r.union_count  = CNT_W'(uni);
      r.empty_union  = (uni == 0);
      done = 1'b1;
      common_bits = 0;
      a_bits = 0;
      b_bits = 0;
      pairs_held = 0;
    end
  endtask

  function automatic stim_row_t pair_row(input logic [BYTE_W-1:0] a, b, input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PAIR;
    r.pair.byte_a = a;
    r.pair.byte_b = b;
    r.pair.last_pair = last;
    return r;
  endfunction

  function automatic stim_row_t scored_row(input logic [BYTE_W-1:0] a, b,
                                           input int unsigned sim, common, uni,
                                           input logic empty);
    stim_row_t r;
    r = pair_row(a, b, 1'b1);
    r.typed = 1'b1;
    r.score.similarity = SIM_W'(sim);
    r.score.common_count = CNT_W'(common);
    r.score.union_count = CNT_W'(uni);
    r.score.empty_union = empty;
    return r;
  endfunction

  function automatic stim_row_t mode_row(input logic m);
    stim_row_t r;
    r = '0;
    r.kind = ROW_MODE;
    r.mode = m;
    return r;
  endfunction

  function automatic fts_in_t rand_pair();
    fts_in_t p;
    p.byte_a = BYTE_W'($urandom);
    p.byte_b = BYTE_W'($urandom);
    p.last_pair = 1'b0;
    case ($urandom_range(0, 7))
      0: p.byte_b = p.byte_a;
      1: p.byte_b = p.byte_a ^ (BYTE_W'(1) << $urandom_range(0, BIT_TOP));
      2: p.byte_a = '0;
      3: p.byte_a = '1;
      4: begin
        p.byte_a = '0;
        p.byte_b = '0;
      end
      5: begin
        p.byte_a = '1;
        p.byte_b = '1;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pair(input fts_in_t p, input logic typed, input fts_out_t given);
    int unsigned gap;
    bit          done;
    fts_out_t    score;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_pair(p, done, score);
    if (done) pending_scores.push_back(typed ? given : score);
    pairs_sent++;
  endtask

  // drain all scores, then give the divider time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DIVIDE_SETTLE) @(posedge clk);
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write then read back; psel stays high across the two transfers
  task automatic set_mode(input logic m);
    logic [PDATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= PDATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mode_now = m;
    apb_read(MODE_ADDR, rd);
    check_field("compare_mode", m, rd);
  endtask

  always @(posedge clk) begin
    fts_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t unexpected score: expected none, got %h", $time, out_data);
      end else begin
        want = pending_scores.pop_front();
        check_field("similarity", want.similarity, out_data.similarity);
        check_field("common_count", want.common_count, out_data.common_count);
        check_field("union_count", want.union_count, out_data.union_count);
        check_field("empty_union", want.empty_union, out_data.empty_union);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : rx_pacing
    int unsigned hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 7);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [PDATA_W-1:0] rd;
    fts_in_t            p;
    fts_out_t           full;
    int unsigned        random_end;
    int unsigned        next_switch;
    int unsigned        len;
    int unsigned        pick;
    bit                 squeezed;

    dir_rows = '{
      scored_row(8'h00, 8'h00, 0, 0, 0, 1'b1),       // empty union
      scored_row(8'hff, 8'hff, 65536, 8, 8, 1'b0),
      scored_row(8'hff, 8'h00, 0, 0, 8, 1'b0),
      pair_row(8'hf0, 8'h3c, 1'b0),
      pair_row(8'h0f, 8'h0f, 1'b1),
      scored_row(8'h55, 8'haa, 0, 0, 8, 1'b0),
      scored_row(8'h01, 8'h03, 32768, 1, 2, 1'b0),
      pair_row(8'h80, 8'h80, 1'b0),
      mode_row(MODE_BYTES),                           // switch inside a fingerprint
      pair_row(8'h12, 8'h12, 1'b0),
      pair_row(8'h12, 8'h34, 1'b1),
      scored_row(8'h00, 8'h00, 65536, 1, 1, 1'b0),
      scored_row(8'h7f, 8'hfe, 0, 0, 2, 1'b0),
      pair_row(8'ha5, 8'ha5, 1'b0),
      mode_row(MODE_BITS),
      pair_row(8'h3c, 8'hc3, 1'b0),
      pair_row(8'hff, 8'h0f, 1'b1),
      pair_row(8'h96, 8'h69, 1'b0),
      pair_row(8'h00, 8'hff, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    apb_read(MODE_ADDR, rd);
    check_field("compare_mode", MODE_BITS, rd);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MODE) begin
        settle();
        set_mode(dir_rows[i].mode);
      end else begin
        send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].score);
      end
    end

    // pairs past the limit are dropped, counts stop at 8 * PAIR_LIMIT
    full.similarity = SIM_W'(65536);
    full.common_count = CNT_W'(8 * PAIR_LIMIT);
    full.union_count = CNT_W'(8 * PAIR_LIMIT);
    full.empty_union = 1'b0;
    for (int i = 0; i < PAIR_LIMIT + 4; i++) begin
      p.byte_a = '1;
      p.byte_b = '1;
      p.last_pair = (i == PAIR_LIMIT + 3);
      send_pair(p, 1'b1, full);
    end

    random_end = pairs_sent + RANDOM_PAIRS;
    next_switch = pairs_sent + $urandom_range(100, 250);
    squeezed = 1'b0;
    while (pairs_sent < random_end) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) len = $urandom_range(PAIR_LIMIT - 6, PAIR_LIMIT + 14);
      else if (pick < 6) len = 1;
      else len = $urandom_range(2, 16);
      quiet = ($urandom_range(0, 7) == 0);
      // long receiver hold while short fingerprints keep coming
      if (!squeezed && pairs_sent >= random_end - RANDOM_PAIRS / 2) begin
        squeezed = 1'b1;
        hold_req = 1'b1;
        quiet = 1'b1;
        repeat (40) begin
          p = rand_pair();
          p.last_pair = 1'b1;
          send_pair(p, 1'b0, '0);
        end
      end
      for (int i = 0; i < len; i++) begin
        p = rand_pair();
        p.last_pair = (i == len - 1);
        send_pair(p, 1'b0, '0);
        if (pairs_sent >= next_switch) begin
          settle();
          set_mode(~mode_now);
          next_switch = pairs_sent + $urandom_range(100, 250);
        end
      end
    end

    quiet = 1'b0;
    settle();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/fts_pkg.sv
rtl/fts_ctrl.sv
rtl/fts_dp.sv
rtl/fingerprint_tanimoto_similarity_core.sv
bench/testbench.sv
